@@ design/depth_tested_line_rasterizer_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the depth-tested line rasterizer
// Each macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef DEPTH_TESTED_LINE_RASTERIZER_MACROS_SVH
`define DEPTH_TESTED_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication
`define DTLR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtlr: same-cycle check failed");

// next-cycle implication
`define DTLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtlr: next-cycle check failed");

`endif

@@ design/dtlr_pkg.sv @@
// ---------------------------------------------------------------------------
// dtlr_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package dtlr_pkg;

	localparam int SCREEN_WIDTH  = 32;
	localparam int SCREEN_HEIGHT = 32;
	localparam int STORE_DEPTH   = 1024;
	localparam int IDX_W         = $clog2(STORE_DEPTH);

	localparam int COORD_W  = 9;
	localparam int FRAC_W   = 4;
	localparam int DEPTH_W  = 16;
	localparam int COLOUR_W = 32;
	localparam int PIX_W    = 6;
	localparam int CHAN_W   = 8;
	localparam int STEP_W   = 6;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 40;

	localparam logic OP_DRAW  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic load;
		logic set1;
		logic set2;
		logic walk;
		logic clr;
	} dtlr_cmd_t;

	typedef struct packed {
		logic adv;
		logic last_dot;
		logic clr_done;
		logic pipe_busy;
	} dtlr_status_t;

endpackage

@@ design/dtlr_ctrl.sv @@
// ---------------------------------------------------------------------------
// dtlr_ctrl
// Command sequencer: clear sweep, line setup, dot walk and pipeline drain.
// ---------------------------------------------------------------------------
module dtlr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_opcode,
	output logic                  in_ready,
	input  dtlr_pkg::dtlr_status_t status,
	output dtlr_pkg::dtlr_cmd_t   cmd
);
	import dtlr_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SET1  = 3'd2;
	localparam logic [2:0] ST_SET2  = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		cmd.load = accept && (in_opcode == OP_DRAW);
		cmd.set1 = (state_q == ST_SET1);
		cmd.set2 = (state_q == ST_SET2);
		cmd.walk = (state_q == ST_WALK);
		cmd.clr  = (state_q == ST_CLEAR);
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_n = (in_opcode == OP_CLEAR) ? ST_CLEAR : ST_SET1;
			end
			ST_SET1: state_n = ST_SET2;
			ST_SET2: state_n = ST_WALK;
			ST_WALK: begin
				if (status.adv && status.last_dot) state_n = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ design/dtlr_datapath.sv @@
// ---------------------------------------------------------------------------
// dtlr_datapath
// Line setup, incremental dot walker, depth store and colour pipeline.
// ---------------------------------------------------------------------------
`include "depth_tested_line_rasterizer_macros.svh"

module dtlr_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dtlr_pkg::dtlr_cmd_t                  cmd,
	output dtlr_pkg::dtlr_status_t               status,
	input  logic [dtlr_pkg::COORD_W-1:0]         start_x,
	input  logic [dtlr_pkg::COORD_W-1:0]         start_y,
	input  logic signed [dtlr_pkg::DEPTH_W-1:0]  start_depth,
	input  logic [dtlr_pkg::COLOUR_W-1:0]        start_colour,
	input  logic [dtlr_pkg::COORD_W-1:0]         end_x,
	input  logic [dtlr_pkg::COORD_W-1:0]         end_y,
	input  logic signed [dtlr_pkg::DEPTH_W-1:0]  end_depth,
	input  logic [dtlr_pkg::COLOUR_W-1:0]        end_colour,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dtlr_pkg::PIX_W-1:0]           pixel_x,
	output logic [dtlr_pkg::PIX_W-1:0]           pixel_y,
	output logic                                 drawn,
	output logic [dtlr_pkg::CHAN_W-1:0]          red,
	output logic [dtlr_pkg::CHAN_W-1:0]          green,
	output logic [dtlr_pkg::CHAN_W-1:0]          blue,
	output logic                                 last
);
	import dtlr_pkg::*;

	localparam int DX_W     = COORD_W + 1;
	localparam int RX_W     = COORD_W + 3;
	localparam int DZ_W     = DEPTH_W + 1;
	localparam int ZQ_W     = DEPTH_W + 2;
	localparam int ACC_W    = CHAN_W + STEP_W - 1;
	localparam int PROD_W   = 2 * ACC_W;
	localparam int RD_W     = 32;
	localparam int RS_W     = DEPTH_W + 1;
	localparam int DEN_W    = 18;
	localparam int RECIP_SH = 39;
	localparam int PP_W     = PROD_W + RD_W;
	localparam int DZP_W    = DEPTH_W + RS_W;
	localparam int QS_W     = DEPTH_W + STEP_W;
	localparam int SIDX_W   = STEP_W - 1;
	localparam int STEP_MAX = 1 << SIDX_W;
	localparam int LIN_W    = 16;
	localparam int NCH      = 4;
	localparam int ALPHA    = 3;

	// reciprocal tables indexed by steps-1
	logic [RD_W-1:0]  recip_den [STEP_MAX];
	logic [DEN_W-1:0] den_tbl   [STEP_MAX];
	logic [RS_W-1:0]  recip_s   [STEP_MAX];

	for (genvar g = 0; g < STEP_MAX; g++) begin : g_tbl
		localparam longint SV  = g + 1;
		localparam longint DV  = 255 * SV * SV;
		localparam longint RDV = (longint'(1) << RECIP_SH) / DV;
		localparam longint RSV = (longint'(1) << DEPTH_W) / SV;
		assign recip_den[g] = RD_W'(RDV);
		assign den_tbl[g]   = DEN_W'(DV);
		assign recip_s[g]   = RS_W'(RSV);
	end

	// line registers
	logic [COORD_W-1:0]       x1_q, y1_q;
	logic signed [DX_W-1:0]   dx_q, dy_q;
	logic signed [DEPTH_W-1:0] z1_q;
	logic signed [DZ_W-1:0]   dz_q;
	logic [CHAN_W-1:0]        c1_q [NCH];
	logic signed [CHAN_W:0]   dc_q [NCH];
	logic [STEP_W-1:0]        s_q;
	logic [DEPTH_W-1:0]       adz_q;
	logic [DZP_W-1:0]         dzp_q;
	logic signed [ZQ_W-1:0]   dq_q;
	logic [STEP_W-1:0]        dr_q;

	// walker registers
	logic [PIX_W-1:0]         qx_q, qy_q;
	logic signed [RX_W-1:0]   rx_q, ry_q;
	logic signed [ZQ_W-1:0]   zq_q;
	logic [STEP_W-1:0]        zr_q;
	logic [ACC_W-1:0]         acc_q [NCH];
	logic [STEP_W-1:0]        i_q;

	// pipeline
	logic                     v_s1, v_s2, out_v_q;
	logic [PIX_W-1:0]         px_s1, py_s1, px_s2, py_s2;
	logic signed [ZQ_W-1:0]   z_s1;
	logic                     inb_s1, last_s1, last_s2, drawn_s2;
	logic [IDX_W-1:0]         idx_s1;
	logic [PROD_W-1:0]        x_s1 [3];
	logic [PROD_W-1:0]        x_s2 [3];
	logic [PP_W-1:0]          p_s2 [3];
	logic [PIX_W-1:0]         out_px_q, out_py_q;
	logic                     out_drawn_q, out_last_q;
	logic [CHAN_W-1:0]        out_c_q [3];

	// depth store
	logic [DEPTH_W-1:0]       store [STORE_DEPTH];
	logic [DEPTH_W-1:0]       rd_q;
	logic                     fwd_v_q;
	logic [IDX_W-1:0]         fwd_idx_q;
	logic [DEPTH_W-1:0]       fwd_dat_q;
	logic [IDX_W-1:0]         clr_cnt_q;

	// combinational
	logic                     adv, emit, pass;
	logic [SIDX_W-1:0]        sidx;
	logic [STEP_W-1:0]        s_m1;
	logic signed [DX_W-1:0]   ld_dx, ld_dy;
	logic [COORD_W-1:0]       ld_adx, ld_ady, ld_m;
	logic [STEP_W-1:0]        ld_s;
	logic signed [DZ_W-1:0]   ld_dz;
	logic [COORD_W:0]         xp8, yp8;
	logic [DEPTH_W-1:0]       set_adz;
	logic [DEPTH_W-1:0]       qe;
	logic [QS_W-1:0]          qs, rem;
	logic                     rem_ge;
	logic [DEPTH_W:0]         qf;
	logic [STEP_W-1:0]        rf;
	logic signed [RX_W-1:0]   s16, rx_n, ry_n;
	logic [STEP_W:0]          zr_n;
	logic                     zc;
	logic [LIN_W-1:0]         lin;
	logic [IDX_W-1:0]         wk_idx;
	logic [DEPTH_W-1:0]       st_val, zq16;

	assign adv  = !out_v_q || out_ready;
	assign emit = cmd.walk && adv;
	assign s_m1 = s_q - STEP_W'(1);
	assign sidx = s_m1[SIDX_W-1:0];

	// load-time arithmetic
	assign ld_dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
	assign ld_dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
	assign ld_adx = ld_dx[DX_W-1] ? COORD_W'(-ld_dx) : ld_dx[COORD_W-1:0];
	assign ld_ady = ld_dy[DX_W-1] ? COORD_W'(-ld_dy) : ld_dy[COORD_W-1:0];
	assign ld_m   = (ld_adx > ld_ady) ? ld_adx : ld_ady;
	assign ld_s   = {1'b0, ld_m[COORD_W-1:FRAC_W]} + STEP_W'(1);
	assign ld_dz  = $signed({end_depth[DEPTH_W-1], end_depth})
	              - $signed({start_depth[DEPTH_W-1], start_depth});

	// setup arithmetic
	assign xp8     = {1'b0, x1_q} + (COORD_W+1)'(8);
	assign yp8     = {1'b0, y1_q} + (COORD_W+1)'(8);
	assign set_adz = dz_q[DZ_W-1] ? DEPTH_W'(-dz_q) : dz_q[DEPTH_W-1:0];
	assign qe      = dzp_q[DEPTH_W+DEPTH_W-1:DEPTH_W];
	assign qs      = QS_W'(qe) * QS_W'(s_q);
	assign rem     = QS_W'(adz_q) - qs;
	assign rem_ge  = rem >= QS_W'(s_q);
	assign qf      = (DEPTH_W+1)'(qe) + (DEPTH_W+1)'(rem_ge);
	assign rf      = rem_ge ? STEP_W'(rem - QS_W'(s_q)) : STEP_W'(rem);

	// walk arithmetic
	assign s16  = $signed(RX_W'({s_q, {FRAC_W{1'b0}}}));
	assign rx_n = rx_q + RX_W'(dx_q);
	assign ry_n = ry_q + RX_W'(dy_q);
	assign zr_n = {1'b0, zr_q} + {1'b0, dr_q};
	assign zc   = zr_n >= {1'b0, s_q};
	assign lin  = LIN_W'(qy_q) * LIN_W'(SCREEN_WIDTH) + LIN_W'(qx_q);
	assign wk_idx = lin[IDX_W-1:0];

	// depth test with one-back forwarding of the previous write
	assign st_val = (fwd_v_q && fwd_idx_q == idx_s1) ? fwd_dat_q : rd_q;
	assign zq16   = z_s1[DEPTH_W-1:0];
	assign pass   = v_s1 && inb_s1 && (st_val == '0 || zq16 <= st_val);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= start_x;
			y1_q <= start_y;
			dx_q <= ld_dx;
			dy_q <= ld_dy;
			z1_q <= start_depth;
			dz_q <= ld_dz;
			s_q  <= ld_s;
			for (int k = 0; k < NCH; k++) begin
				c1_q[k] <= start_colour[COLOUR_W-1-CHAN_W*k -: CHAN_W];
				dc_q[k] <= $signed({1'b0, end_colour[COLOUR_W-1-CHAN_W*k -: CHAN_W]})
				         - $signed({1'b0, start_colour[COLOUR_W-1-CHAN_W*k -: CHAN_W]});
			end
		end
		if (cmd.set1) begin
			qx_q  <= xp8[COORD_W:FRAC_W];
			qy_q  <= yp8[COORD_W:FRAC_W];
			rx_q  <= $signed(RX_W'(xp8[FRAC_W-1:0]) * RX_W'(s_q));
			ry_q  <= $signed(RX_W'(yp8[FRAC_W-1:0]) * RX_W'(s_q));
			zq_q  <= ZQ_W'(z1_q);
			zr_q  <= '0;
			adz_q <= set_adz;
			dzp_q <= DZP_W'(set_adz) * DZP_W'(recip_s[sidx]);
			i_q   <= '0;
			for (int k = 0; k < NCH; k++) begin
				acc_q[k] <= ACC_W'(c1_q[k]) * ACC_W'(s_q);
			end
		end
		if (cmd.set2) begin
			// floor division of the depth delta by the step count
			if (dz_q[DZ_W-1]) begin
				if (rf == '0) begin
					dq_q <= -ZQ_W'(qf);
					dr_q <= '0;
				end else begin
					dq_q <= -(ZQ_W'(qf) + ZQ_W'(1));
					dr_q <= s_q - rf;
				end
			end else begin
				dq_q <= ZQ_W'(qf);
				dr_q <= rf;
			end
		end
		if (emit) begin
			if (rx_n >= s16) begin
				rx_q <= rx_n - s16;
				qx_q <= qx_q + PIX_W'(1);
			end else if (rx_n < 0) begin
				rx_q <= rx_n + s16;
				qx_q <= qx_q - PIX_W'(1);
			end else begin
				rx_q <= rx_n;
			end
			if (ry_n >= s16) begin
				ry_q <= ry_n - s16;
				qy_q <= qy_q + PIX_W'(1);
			end else if (ry_n < 0) begin
				ry_q <= ry_n + s16;
				qy_q <= qy_q - PIX_W'(1);
			end else begin
				ry_q <= ry_n;
			end
			zr_q <= zc ? STEP_W'(zr_n - {1'b0, s_q}) : STEP_W'(zr_n);
			zq_q <= zq_q + dq_q + ZQ_W'(zc);
			i_q  <= i_q + STEP_W'(1);
			for (int k = 0; k < NCH; k++) begin
				acc_q[k] <= ACC_W'($signed({1'b0, acc_q[k]}) + (ACC_W+1)'(dc_q[k]));
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (emit) begin
			px_s1   <= qx_q;
			py_s1   <= qy_q;
			z_s1    <= zq_q;
			last_s1 <= (i_q == s_q);
			idx_s1  <= wk_idx;
			inb_s1  <= (qx_q <= PIX_W'(SCREEN_WIDTH - 1)) && (qy_q <= PIX_W'(SCREEN_HEIGHT - 1))
			           && !zq_q[ZQ_W-1];
			for (int c = 0; c < 3; c++) begin
				x_s1[c] <= PROD_W'(acc_q[c]) * PROD_W'(acc_q[ALPHA]);
			end
		end
		if (adv) begin
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			last_s2  <= last_s1;
			drawn_s2 <= pass;
			for (int c = 0; c < 3; c++) begin
				x_s2[c] <= x_s1[c];
				p_s2[c] <= PP_W'(x_s1[c]) * PP_W'(recip_den[sidx]);
			end
			out_px_q    <= px_s2;
			out_py_q    <= py_s2;
			out_last_q  <= last_s2;
			out_drawn_q <= drawn_s2;
			for (int c = 0; c < 3; c++) begin
				out_c_q[c] <= p_s2[c][RECIP_SH+CHAN_W-1:RECIP_SH]
				            + CHAN_W'((x_s2[c] - PROD_W'(p_s2[c][RECIP_SH+CHAN_W-1:RECIP_SH])
				                       * PROD_W'(den_tbl[sidx])) >= PROD_W'(den_tbl[sidx]));
			end
		end
	end

	// depth store: clear sweep or depth-test write, one read port
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			store[clr_cnt_q] <= '0;
		end else if (adv && pass) begin
			store[idx_s1] <= zq16;
		end
		if (adv) begin
			rd_q <= store[wk_idx];
		end
		if (adv) begin
			fwd_idx_q <= idx_s1;
			fwd_dat_q <= zq16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_v_q   <= 1'b0;
			fwd_v_q   <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (adv) begin
				v_s1    <= emit;
				v_s2    <= v_s1;
				out_v_q <= v_s2;
			end
			if (cmd.clr) begin
				fwd_v_q   <= 1'b0;
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end else if (adv) begin
				fwd_v_q <= pass;
			end
		end
	end

	assign status.adv       = adv;
	assign status.last_dot  = (i_q == s_q);
	assign status.clr_done  = cmd.clr && (clr_cnt_q == {IDX_W{1'b1}});
	assign status.pipe_busy = v_s1 || v_s2;

	assign out_valid = out_v_q;
	assign pixel_x   = out_px_q;
	assign pixel_y   = out_py_q;
	assign drawn     = out_drawn_q;
	assign red       = out_c_q[0];
	assign green     = out_c_q[1];
	assign blue      = out_c_q[2];
	assign last      = out_last_q;

	`DTLR_ASSERT_IMPL(a_clr_pipe_empty, cmd.clr, !v_s1 && !v_s2)
	`DTLR_ASSERT_IMPL(a_load_pipe_empty, cmd.load, !v_s1 && !v_s2 && !cmd.walk)
	`DTLR_ASSERT_IMPL(a_drawn_on_screen, out_v_q && out_drawn_q,
		out_px_q <= PIX_W'(SCREEN_WIDTH - 1) && out_py_q <= PIX_W'(SCREEN_HEIGHT - 1))
	`DTLR_ASSERT_NEXT(a_last_ends_walk, emit && (i_q == s_q), !cmd.walk)

endmodule

@@ design/depth_tested_line_rasterizer.sv @@
// ---------------------------------------------------------------------------
// depth_tested_line_rasterizer
// Walks a line between two endpoints, depth-tests each dot against a 32x32
// depth store and emits one beat per dot with its pixel, colour and result.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one command per beat. tuser selects draw or
//   clear. A draw emits steps+1 beats on m_axis, steps = floor(max|d|/16)+1, at
//   most 33; tlast marks the final dot. A clear emits nothing.
//   A draw runs the setup states SET1 and SET2 after the command beat, then
//   the walker and a three-stage dot pipeline; the walker issues one dot per
//   cycle while the receiver does not stall, and the pipeline then drains
//   before the next command beat is taken.
//   A clear sweeps the 1024-entry store one entry per cycle.
//   Reset: arst_n clears control state and then the same clear pass runs;
//   s_axis_tready stays low until it ends.
//   Receiver stall: when m_axis_tready is low while a dot beat is held, the
//   whole dot pipeline and the walker hold; nothing is lost. s_axis_tready is
//   high only between commands, once the pipeline has written back its last dot.
// ---------------------------------------------------------------------------
module depth_tested_line_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// start_x, start_y, start_depth, start_colour, end_x, end_y, end_depth,
	// end_colour, zero pad
	input  logic [dtlr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pixel_x, pixel_y, red, green, blue, zero pad
	output logic [dtlr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// drawn
	output logic [0:0]                          m_axis_tuser,
	output logic                                m_axis_tlast
);
	import dtlr_pkg::*;

	localparam int SX_LO = 0;
	localparam int SY_LO = SX_LO + COORD_W;
	localparam int SZ_LO = SY_LO + COORD_W;
	localparam int SC_LO = SZ_LO + DEPTH_W;
	localparam int EX_LO = SC_LO + COLOUR_W;
	localparam int EY_LO = EX_LO + COORD_W;
	localparam int EZ_LO = EY_LO + COORD_W;
	localparam int EC_LO = EZ_LO + DEPTH_W;
	localparam int IN_USED = EC_LO + COLOUR_W;
	localparam int OUT_USED = 2 * PIX_W + 3 * CHAN_W;

	dtlr_cmd_t         cmd;
	dtlr_status_t      status;
	logic [PIX_W-1:0]  pixel_x, pixel_y;
	logic [CHAN_W-1:0] red, green, blue;
	logic              drawn;

	// sequencer: accept, setup, walk, drain, clear
	dtlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_opcode(s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// walker, depth store and colour pipeline
	dtlr_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.start_x     (s_axis_tdata[SX_LO +: COORD_W]),
		.start_y     (s_axis_tdata[SY_LO +: COORD_W]),
		.start_depth ($signed(s_axis_tdata[SZ_LO +: DEPTH_W])),
		.start_colour(s_axis_tdata[SC_LO +: COLOUR_W]),
		.end_x       (s_axis_tdata[EX_LO +: COORD_W]),
		.end_y       (s_axis_tdata[EY_LO +: COORD_W]),
		.end_depth   ($signed(s_axis_tdata[EZ_LO +: DEPTH_W])),
		.end_colour  (s_axis_tdata[EC_LO +: COLOUR_W]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.drawn       (drawn),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (m_axis_tlast)
	);

	// pack the result beat, pad bits tied low
	assign m_axis_tdata = {{(OUT_DATA_W-OUT_USED){1'b0}}, blue, green, red, pixel_y, pixel_x};
	assign m_axis_tuser = drawn;

endmodule

@@ verif/tb_depth_tested_line_rasterizer.sv @@
// ---------------------------------------------------------------------------
// tb_depth_tested_line_rasterizer
// Self-checking bench for the line rasterizer. Command beats come from a
// pending queue and are fed through a clocked driver. A line predictor with
// its own depth store works out every dot beat. A clocked monitor checks the
// dot beats in order while both sides idle at random, except in the last third.
// ---------------------------------------------------------------------------
module tb_depth_tested_line_rasterizer;
	import dtlr_pkg::*;

	typedef struct {
		logic        op;
		logic [8:0]  x1, y1, x2, y2;
		logic [15:0] z1, z2;
		logic [31:0] c1, c2;
	} line_cmd_t;

	typedef struct {
		logic [5:0] px, py;
		logic       drawn;
		logic [7:0] r, g, b;
		logic       last;
	} dot_t;

	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	line_cmd_t   pending_cmds[$];
	line_cmd_t   cmd_on_bus;
	dot_t        expected_dots[$];
	logic [15:0] model_depth[STORE_DEPTH];

	int total_cmds, sent_cmds, draw_count, clear_count;
	int dot_count, drawn_count, mismatches;
	int send_idle_pct, recv_idle_pct;
	int unsigned cycle_count;

	depth_tested_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Build a command; all position and colour fields are raw bus values.
	function automatic line_cmd_t mk(logic op, int x1, int y1, int z1, logic [31:0] c1,
			int x2, int y2, int z2, logic [31:0] c2);
		line_cmd_t c;
		c.op = op; c.x1 = 9'(x1); c.y1 = 9'(y1); c.z1 = 16'(z1); c.c1 = c1;
		c.x2 = 9'(x2); c.y2 = 9'(y2); c.z2 = 16'(z2); c.c2 = c2;
		return c;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_cmd(line_cmd_t c);
		return {4'b0, c.c2, c.z2, c.y2, c.x2, c.c1, c.z1, c.y1, c.x1};
	endfunction

	// Walk the line exactly as numerators over steps and queue steps+1 dots, ends included.
	task automatic rasterize_line(line_cmd_t c);
		longint x1, y1, x2, y2, z1, z2, adx, ady, m, s, i;
		longint nx, ny, nz, px, py, na, nc, den, zq;
		int     idx, ch;
		dot_t   d;
		if (c.op == OP_CLEAR) begin
			foreach (model_depth[k]) model_depth[k] = '0;
			clear_count++;
			return;
		end
		draw_count++;
		x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
		z1 = $signed(c.z1); z2 = $signed(c.z2);
		adx = (x2 > x1) ? x2 - x1 : x1 - x2;
		ady = (y2 > y1) ? y2 - y1 : y1 - y2;
		m = (adx > ady) ? adx : ady;
		s = m / 16 + 1;
		den = 255 * s * s;
		for (i = 0; i <= s; i++) begin
			nx = x1 * s + (x2 - x1) * i;
			ny = y1 * s + (y2 - y1) * i;
			nz = z1 * s + (z2 - z1) * i;
			px = (nx + 8 * s) / (16 * s);
			py = (ny + 8 * s) / (16 * s);
			na = longint'(c.c1[7:0]) * s + (longint'(c.c2[7:0]) - longint'(c.c1[7:0])) * i;
			d.drawn = 1'b0;
			if (px <= SCREEN_WIDTH - 1 && py <= SCREEN_HEIGHT - 1 && nz >= 0) begin
				zq = nz / s;
				idx = int'((py * SCREEN_WIDTH + px) & (STORE_DEPTH - 1));
				if (model_depth[idx] == 0 || zq <= longint'(model_depth[idx])) begin
					model_depth[idx] = zq[15:0];
					d.drawn = 1'b1;
				end
			end
			d.px = px[5:0];
			d.py = py[5:0];
			for (ch = 0; ch < 3; ch++) begin
				nc = longint'(c.c1[31-8*ch -: 8]) * s
					+ (longint'(c.c2[31-8*ch -: 8]) - longint'(c.c1[31-8*ch -: 8])) * i;
				nc = (nc * na) / den;
				if (ch == 0) d.r = nc[7:0];
				else if (ch == 1) d.g = nc[7:0];
				else d.b = nc[7:0];
			end
			d.last = (i == s);
			expected_dots.push_back(d);
		end
	endtask

	// Idle mix by progress: receiver-heavy third, sender-heavy third, then none.
	always_comb begin
		if (sent_cmds < total_cmds / 3) begin
			send_idle_pct = 32; recv_idle_pct = 55;
		end else if (sent_cmds < 2 * total_cmds / 3) begin
			send_idle_pct = 55; recv_idle_pct = 32;
		end else begin
			send_idle_pct = 0; recv_idle_pct = 0;
		end
	end

	// Driver: predict on every accepted command beat, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				rasterize_line(cmd_on_bus);
				sent_cmds++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_on_bus = pending_cmds.pop_front();
					s_axis_tdata  <= pack_cmd(cmd_on_bus);
					s_axis_tuser  <= cmd_on_bus.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted dot beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		dot_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				dot_count++;
				if (expected_dots.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected dot beat: tdata=%h tuser=%b tlast=%b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					e = expected_dots.pop_front();
					if (e.drawn) drawn_count++;
					if (m_axis_tdata[5:0] !== e.px || m_axis_tdata[11:6] !== e.py
							|| m_axis_tdata[19:12] !== e.r || m_axis_tdata[27:20] !== e.g
							|| m_axis_tdata[35:28] !== e.b || m_axis_tuser[0] !== e.drawn
							|| m_axis_tlast !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"dot mismatch: exp x=%0d y=%0d drawn=%b rgb=%h %h %h ",
								"last=%b / got x=%0d y=%0d drawn=%b rgb=%h %h %h last=%b"},
								e.px, e.py, e.drawn, e.r, e.g, e.b, e.last,
								m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tuser[0],
								m_axis_tdata[19:12], m_axis_tdata[27:20], m_axis_tdata[35:28],
								m_axis_tlast);
					end
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int n, kind, bx, by;
		line_cmd_t c;
		foreach (model_depth[k]) model_depth[k] = '0;

		// Directed: extremes, clear, coincident endpoints, off-screen, depth cases.
		pending_cmds.push_back(mk(OP_DRAW, 0, 0, 16'h0100, 32'hFFFFFFFF,
			511, 511, 16'h7FFF, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(OP_DRAW, 511, 0, 16'h7FFF, 32'h00000000,
			0, 511, 16'h0000, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(OP_DRAW, 100, 100, 16'h0200, 32'h80402010,
			100, 100, 16'h0200, 32'h80402010));
		pending_cmds.push_back(mk(OP_DRAW, 0, 0, 16'h0080, 32'hFFFFFFFF,
			511, 0, 16'h0080, 32'hFF0000FF));
		pending_cmds.push_back(mk(OP_DRAW, 0, 0, 16'h0001, 32'h12345678,
			511, 0, 16'h7000, 32'h9ABCDEF0));
		pending_cmds.push_back(mk(OP_DRAW, 0, 0, 16'h8000, 32'hFF00FF00,
			200, 300, 16'hFFFF, 32'h00FF00FF));
		pending_cmds.push_back(mk(OP_DRAW, 40, 40, 16'h0000, 32'hFFFFFF80,
			240, 40, 16'h0000, 32'hFFFFFF80));
		pending_cmds.push_back(mk(OP_DRAW, 40, 40, 16'h0300, 32'hA0A0A0A0,
			240, 40, 16'h0300, 32'hA0A0A0A0));
		pending_cmds.push_back(mk(OP_DRAW, 40, 40, 16'h0100, 32'h55AA55AA,
			240, 40, 16'h0500, 32'hAA55AA55));
		pending_cmds.push_back(mk(OP_DRAW, 500, 505, 16'h8000, 32'h00000000,
			511, 511, 16'h8001, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(OP_DRAW, 0, 511, 16'h0400, 32'h01020304,
			0, 0, 16'hFF00, 32'hF0E0D0C0));
		pending_cmds.push_back(mk(OP_CLEAR, 511, 511, 16'hFFFF, 32'hFFFFFFFF,
			511, 511, 16'hFFFF, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(OP_DRAW, 40, 40, 16'h0300, 32'hFFFFFFFF,
			240, 40, 16'h0300, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(OP_DRAW, 300, 7, 16'h7FFF, 32'hFFFFFF00,
			15, 255, 16'h0001, 32'h000000FF));
		pending_cmds.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));

		// Random: mostly lines clustered over small regions so the depth test
		// both passes and fails; a few wide-open random beats and rare clears.
		for (n = 0; n < 450; n++) begin
			kind = $urandom_range(99);
			c.c1 = $urandom; c.c2 = $urandom;
			c.op = OP_DRAW;
			if (kind < 4) begin
				c.op = OP_CLEAR;
				c.x1 = 9'($urandom); c.y1 = 9'($urandom);
				c.x2 = 9'($urandom); c.y2 = 9'($urandom);
				c.z1 = 16'($urandom); c.z2 = 16'($urandom);
			end else if (kind < 20) begin
				c.x1 = 9'($urandom); c.y1 = 9'($urandom);
				c.x2 = 9'($urandom); c.y2 = 9'($urandom);
				c.z1 = 16'($urandom); c.z2 = 16'($urandom);
			end else begin
				bx = $urandom_range(0, 400); by = $urandom_range(0, 400);
				c.x1 = 9'(bx + $urandom_range(0, 111)); c.y1 = 9'(by + $urandom_range(0, 111));
				c.x2 = 9'(bx + $urandom_range(0, 111)); c.y2 = 9'(by + $urandom_range(0, 111));
				c.z1 = 16'($urandom_range(0, 16'h0FFF)); c.z2 = 16'($urandom_range(0, 16'h0FFF));
				if ($urandom_range(9) == 0) c.z2 = 16'(16'hFFFF - $urandom_range(0, 16'h00FF));
			end
			pending_cmds.push_back(c);
		end
		total_cmds = pending_cmds.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all commands sent, all dots seen, then a short quiet period.
		wait (pending_cmds.size() == 0 && sent_cmds == total_cmds
			&& expected_dots.size() == 0);
		repeat (100) @(posedge clk);

		$display("ran %0d commands: %0d lines, %0d depth clears", total_cmds,
			draw_count, clear_count);
		$display("checked %0d dot beats, %0d of them drawn, %0d mismatches",
			dot_count, drawn_count, mismatches);
		if (mismatches == 0 && expected_dots.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
